@@ design/sphd_pkg.sv @@
// Shared types and constants for the peak-and-hold solenoid driver.
// Holds command, mode, status and event codes plus the beat structs.
// No dependencies.
`default_nettype none

package sphd_pkg;

  // Fixed limits of the driver.
  localparam logic [15:0] MAX_PULSE_MS = 16'd10000;
  localparam logic [9:0]  FULL_DUTY    = 10'd1000;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_PULL_IN_TIME = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_DUTY    = 2'd1;

  // Reset values of the configuration registers.
  localparam logic [15:0] PULL_IN_RESET = 16'd100;
  localparam logic [9:0]  HOLD_RESET    = 10'd300;

  // Command codes.
  typedef enum logic [2:0] {
    OP_GRIP    = 3'd0,
    OP_RELEASE = 3'd1,
    OP_ON      = 3'd2,
    OP_PULSE   = 3'd3,
    OP_TICK    = 3'd4
  } op_t;

  // Reported status codes.
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BUSY   = 2'd1,
    ST_OUTERR = 2'd2,
    ST_BADDUR = 2'd3
  } status_t;

  // Reported mode codes.
  localparam logic [2:0] MODE_OFF   = 3'd0;
  localparam logic [2:0] MODE_PULL  = 3'd1;
  localparam logic [2:0] MODE_HOLD  = 3'd2;
  localparam logic [2:0] MODE_ON    = 3'd3;
  localparam logic [2:0] MODE_PULSE = 3'd4;
  localparam logic [2:0] MODE_FAULT = 3'd5;

  // Driver state machine, one-hot.
  typedef enum logic [5:0] {
    S_OFF   = 6'b000001,
    S_PULL  = 6'b000010,
    S_HOLD  = 6'b000100,
    S_ON    = 6'b001000,
    S_PULSE = 6'b010000,
    S_FAULT = 6'b100000
  } mode_t;

  // Event counter slots.
  localparam int EV_GRIP  = 0;
  localparam int EV_REL   = 1;
  localparam int EV_PULSE = 2;
  localparam int EV_ON    = 3;
  localparam int EV_AUTO  = 4;
  localparam int EV_FAULT = 5;
  localparam int EV_N     = 6;

  // One command beat as held in the input register.
  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] now_ms;
    logic [15:0] pulse_duration_ms;
    logic        drive_ok;
  } cmd_t;

  // One result beat.
  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  mode;
    logic [9:0]  drive_duty;
    logic        continuous;
    logic [15:0] time_left_ms;
    logic [15:0] requested_pulse_ms;
    logic [31:0] grips_total;
    logic [31:0] releases_total;
    logic [31:0] pulses_total;
    logic [31:0] ons_total;
    logic [31:0] auto_offs_total;
    logic [31:0] faults_total;
  } res_t;

  // Map the one-hot state onto the reported mode code.
  function automatic logic [2:0] mode_code(input mode_t m);
    logic [2:0] c;
    unique case (m)
      S_OFF:   c = MODE_OFF;
      S_PULL:  c = MODE_PULL;
      S_HOLD:  c = MODE_HOLD;
      S_ON:    c = MODE_ON;
      S_PULSE: c = MODE_PULSE;
      S_FAULT: c = MODE_FAULT;
      default: c = MODE_OFF;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ design/sphd_ifs.sv @@
// Valid/ready channel interfaces for the solenoid driver command and result beats.
// Depends on nothing; field names match the driver's ports.
`default_nettype none

interface sphd_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [31:0] now_ms;
  logic [15:0] pulse_duration_ms;
  logic        drive_ok;

  modport source (output valid, output op, output now_ms, output pulse_duration_ms,
                  output drive_ok, input ready);
  modport sink   (input valid, input op, input now_ms, input pulse_duration_ms,
                  input drive_ok, output ready);
endinterface

interface sphd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [2:0]  mode;
  logic [9:0]  drive_duty;
  logic        continuous;
  logic [15:0] time_left_ms;
  logic [15:0] requested_pulse_ms;
  logic [31:0] grips_total;
  logic [31:0] releases_total;
  logic [31:0] pulses_total;
  logic [31:0] ons_total;
  logic [31:0] auto_offs_total;
  logic [31:0] faults_total;

  modport source (output valid, output status, output mode, output drive_duty,
                  output continuous, output time_left_ms, output requested_pulse_ms,
                  output grips_total, output releases_total, output pulses_total,
                  output ons_total, output auto_offs_total, output faults_total,
                  input ready);
  modport sink   (input valid, input status, input mode, input drive_duty,
                  input continuous, input time_left_ms, input requested_pulse_ms,
                  input grips_total, input releases_total, input pulses_total,
                  input ons_total, input auto_offs_total, input faults_total,
                  output ready);
endinterface

`default_nettype wire

@@ design/sphd_in_reg.sv @@
// Input register of the solenoid driver: captures one command beat.
// Depends on sphd_pkg and sphd_in_if.
`default_nettype none

module sphd_in_reg
  import sphd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  sphd_in_if.sink     in_ch,
  input  wire logic   advance,
  output logic        cmd_valid,
  output cmd_t        cmd
);

  logic valid_r;
  logic valid_nxt;
  cmd_t cmd_r;
  logic take;

  // Space is free when empty or when the held beat moves on this cycle.
  assign in_ch.ready = !valid_r || advance;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  // Control bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (take) begin
      cmd_r <= '{op: in_ch.op, now_ms: in_ch.now_ms,
                 pulse_duration_ms: in_ch.pulse_duration_ms, drive_ok: in_ch.drive_ok};
    end
  end

  assign cmd_valid = valid_r;
  assign cmd       = cmd_r;

endmodule

`default_nettype wire

@@ design/sphd_core.sv @@
// Driver state, event counters and configuration registers, with the
// combinational command evaluation. Depends on sphd_pkg.
`default_nettype none

module sphd_core
  import sphd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  fire,
  input  wire cmd_t                  cmd,
  output res_t                       res
);

  logic [15:0] pull_in_r;
  logic [9:0]  hold_r;
  mode_t       mode_r, mode_nxt;
  logic [31:0] dl_r, dl_nxt;
  logic [15:0] pl_r, pl_nxt;
  logic [9:0]  duty_r, duty_nxt;
  logic [31:0] cnt_r   [EV_N];
  logic [31:0] cnt_nxt [EV_N];

  logic [31:0] diff_cur;
  logic [31:0] diff_nxt;
  logic        reached_cur;
  logic [9:0]  hold_sat;
  logic        dur_bad;
  logic        rel_req;
  logic        flt_req;
  logic        idle;
  status_t     status;
  logic [15:0] left;

  assign diff_cur    = cmd.now_ms - dl_r;
  assign reached_cur = !diff_cur[31];
  assign hold_sat    = (hold_r > FULL_DUTY) ? FULL_DUTY : hold_r;
  assign dur_bad     = (cmd.pulse_duration_ms == 16'd0) ||
                       (cmd.pulse_duration_ms > MAX_PULSE_MS);
  assign idle        = (mode_r == S_OFF);

  // Command evaluation; release and fault are applied after the decode.
  always_comb begin
    mode_nxt = mode_r;
    dl_nxt   = dl_r;
    pl_nxt   = pl_r;
    duty_nxt = duty_r;
    cnt_nxt  = cnt_r;
    status   = ST_OK;
    rel_req  = 1'b0;
    flt_req  = 1'b0;
    unique case (cmd.op)
      OP_GRIP: begin
        if (!idle) begin
          status = ST_BUSY;
        end else if (!cmd.drive_ok) begin
          flt_req = 1'b1;
          status  = ST_OUTERR;
        end else begin
          mode_nxt = S_PULL;
          duty_nxt = FULL_DUTY;
          pl_nxt   = 16'd0;
          dl_nxt   = cmd.now_ms + {16'd0, pull_in_r};
          cnt_nxt[EV_GRIP] = cnt_r[EV_GRIP] + 32'd1;
        end
      end
      OP_RELEASE: begin
        rel_req = 1'b1;
      end
      OP_ON: begin
        if (!idle) begin
          status = ST_BUSY;
        end else if (!cmd.drive_ok) begin
          flt_req = 1'b1;
          status  = ST_OUTERR;
        end else begin
          mode_nxt = S_ON;
          duty_nxt = FULL_DUTY;
          pl_nxt   = 16'd0;
          dl_nxt   = 32'd0;
          cnt_nxt[EV_ON] = cnt_r[EV_ON] + 32'd1;
        end
      end
      OP_PULSE: begin
        if (dur_bad) begin
          rel_req = 1'b1;
          status  = ST_BADDUR;
        end else if (!idle) begin
          status = ST_BUSY;
        end else if (!cmd.drive_ok) begin
          flt_req = 1'b1;
          status  = ST_OUTERR;
        end else begin
          mode_nxt = S_PULSE;
          duty_nxt = FULL_DUTY;
          pl_nxt   = cmd.pulse_duration_ms;
          dl_nxt   = cmd.now_ms + {16'd0, cmd.pulse_duration_ms};
          cnt_nxt[EV_PULSE] = cnt_r[EV_PULSE] + 32'd1;
        end
      end
      OP_TICK: begin
        if (reached_cur && mode_r == S_PULL) begin
          // A zero hold duty always writes.
          if (hold_sat != 10'd0 && !cmd.drive_ok) begin
            flt_req = 1'b1;
          end else begin
            mode_nxt = S_HOLD;
            duty_nxt = hold_sat;
            dl_nxt   = 32'd0;
          end
        end else if (reached_cur && mode_r == S_PULSE) begin
          rel_req = 1'b1;
          cnt_nxt[EV_AUTO] = cnt_r[EV_AUTO] + 32'd1;
        end
      end
      default: begin
      end
    endcase

    // Release drops the coil; it counts unless the driver was already off.
    if (rel_req) begin
      mode_nxt = S_OFF;
      duty_nxt = 10'd0;
      pl_nxt   = 16'd0;
      dl_nxt   = 32'd0;
      if (!idle) begin
        cnt_nxt[EV_REL] = cnt_r[EV_REL] + 32'd1;
      end
    end

    // A failed duty write parks the driver in fault.
    if (flt_req) begin
      mode_nxt = S_FAULT;
      duty_nxt = 10'd0;
      pl_nxt   = 16'd0;
      dl_nxt   = 32'd0;
      cnt_nxt[EV_FAULT] = cnt_r[EV_FAULT] + 32'd1;
    end
  end

  // Time left until the new deadline, when one is pending.
  assign diff_nxt = cmd.now_ms - dl_nxt;
  always_comb begin
    left = 16'd0;
    if ((mode_nxt == S_PULL || mode_nxt == S_PULSE) && diff_nxt[31]) begin
      left = 16'd0 - diff_nxt[15:0];
    end
  end

  // Result beat from the updated state.
  assign res = '{status:             status,
                 mode:               mode_code(mode_nxt),
                 drive_duty:         duty_nxt,
                 continuous:         (mode_nxt == S_HOLD || mode_nxt == S_ON),
                 time_left_ms:       left,
                 requested_pulse_ms: pl_nxt,
                 grips_total:        cnt_nxt[EV_GRIP],
                 releases_total:     cnt_nxt[EV_REL],
                 pulses_total:       cnt_nxt[EV_PULSE],
                 ons_total:          cnt_nxt[EV_ON],
                 auto_offs_total:    cnt_nxt[EV_AUTO],
                 faults_total:       cnt_nxt[EV_FAULT]};

  // Driver state advances once per evaluated command.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= S_OFF;
      dl_r   <= 32'd0;
      pl_r   <= 16'd0;
      duty_r <= 10'd0;
      for (int i = 0; i < EV_N; i++) begin
        cnt_r[i] <= 32'd0;
      end
    end else if (fire) begin
      mode_r <= mode_nxt;
      dl_r   <= dl_nxt;
      pl_r   <= pl_nxt;
      duty_r <= duty_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Configuration registers; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pull_in_r <= PULL_IN_RESET;
      hold_r    <= HOLD_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_PULL_IN_TIME) begin
        pull_in_r <= cfg_wdata;
      end else if (cfg_index == CFG_HOLD_DUTY) begin
        hold_r <= cfg_wdata[9:0];
      end
    end
  end

endmodule

`default_nettype wire

@@ design/sphd_out_reg.sv @@
// Result register of the solenoid driver: holds one result beat for the sink.
// Depends on sphd_pkg and sphd_out_if.
`default_nettype none

module sphd_out_reg
  import sphd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   load,
  input  wire res_t   res,
  output logic        advance,
  sphd_out_if.source  out_ch
);

  logic valid_r;
  logic valid_nxt;
  res_t res_r;

  // A new beat may enter when empty or when the held beat is taken now.
  assign advance = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_ch.valid              = valid_r;
  assign out_ch.status             = res_r.status;
  assign out_ch.mode               = res_r.mode;
  assign out_ch.drive_duty         = res_r.drive_duty;
  assign out_ch.continuous         = res_r.continuous;
  assign out_ch.time_left_ms       = res_r.time_left_ms;
  assign out_ch.requested_pulse_ms = res_r.requested_pulse_ms;
  assign out_ch.grips_total        = res_r.grips_total;
  assign out_ch.releases_total     = res_r.releases_total;
  assign out_ch.pulses_total       = res_r.pulses_total;
  assign out_ch.ons_total          = res_r.ons_total;
  assign out_ch.auto_offs_total    = res_r.auto_offs_total;
  assign out_ch.faults_total       = res_r.faults_total;

endmodule

`default_nettype wire

@@ design/solenoid_pull_in_hold_driver_top.sv @@
// Peak-and-hold solenoid driver. Each command beat (grip, release, on, pulse,
// tick) is captured in an input register and evaluated against the driver
// state combinationally; its result beat is written to an output register,
// from which it is presented. The block accepts one beat per clock while
// results are taken. A stalled result holds the input register, which then
// holds off the input channel. Configuration writes (pull-in time, hold duty)
// take effect at once and are meant for idle periods. Depends on sphd_pkg,
// the channel interfaces, sphd_in_reg, sphd_core and sphd_out_reg.
`default_nettype none

module solenoid_pull_in_hold_driver_top
  import sphd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  sphd_in_if.sink                    in_ch,
  sphd_out_if.source                 out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic cmd_valid;
  cmd_t cmd;
  logic advance;
  logic fire;
  res_t res;

  assign fire = cmd_valid && advance;

  // Input register.
  sphd_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .advance   (advance),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  // State and command evaluation.
  sphd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .cmd       (cmd),
    .res       (res)
  );

  // Result register.
  sphd_out_reg u_out_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (fire),
    .res     (res),
    .advance (advance),
    .out_ch  (out_ch)
  );

  // A stalled command must not change the state it is evaluated against.
  a_stall_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_valid && !advance && !cfg_we) |=> $stable(res))
    else $error("result changed while the command was stalled");

  // Fault mode always reports a dead coil and no stored pulse.
  a_fault_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.mode == MODE_FAULT) |->
      (out_ch.drive_duty == 10'd0 && out_ch.requested_pulse_ms == 16'd0))
    else $error("fault mode with nonzero duty or pulse length");

  // Driven duty never exceeds full duty.
  a_duty_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.drive_duty <= FULL_DUTY))
    else $error("duty above full scale");

endmodule

`default_nettype wire
